[hw/rtl/glpg_pkg.sv]
// Package for the grid line point generator.
// Holds the coordinate widths, the request codes and the request and point payload types.
// It depends on nothing else.
package glpg_pkg;

  localparam int COORD_BITS = 16;
  localparam int FLOOR_BITS = 4;
  localparam int DELTA_W    = COORD_BITS + 1;
  localparam int ERR_W      = COORD_BITS + 3;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [FLOOR_BITS-1:0] floor_t;

  typedef struct packed {
    logic   command;
    coord_t from_x;
    coord_t from_y;
    coord_t to_x;
    coord_t to_y;
    floor_t floor;
    logic   with_corners;
  } cmd_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    floor_t point_floor;
    logic   point_valid;
    logic   last;
  } pnt_t;

endpackage

[hw/rtl/glpg_if.sv]
// Valid/ready channel interfaces of the grid line point generator.
// One carries requests in, the other carries points out; both use types from glpg_pkg.
interface glpg_cmd_if;
  import glpg_pkg::*;
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface glpg_pnt_if;
  import glpg_pkg::*;
  logic valid;
  logic ready;
  pnt_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/grid_line_point_generator.sv]
// Top level of the grid line point generator, an integer Bresenham line walker.
// Depends on glpg_pkg and on the channel interfaces in glpg_if.sv.
//
// The block takes one request per clock cycle unless stalled. A load request sets up a new line and
// gives no point. Each advance request gives exactly one point in the next cycle, held in a result
// register. A new request is accepted only when that register is empty or its point is taken in the
// same cycle, so a stalled consumer also stalls the requests. The rate of one point per cycle when
// not stalled is set by the single Bresenham step between the line state registers and the result
// register. The start tile is never given and the end tile always is, marked with last, unless it
// equals the start tile. In corners mode a diagonal step comes out as two points, the x move first.
// An advance with no line in progress gives a point with point_valid low and all fields zero.
module grid_line_point_generator
  import glpg_pkg::*;
(
  input logic       clk,
  input logic       rst,
  glpg_cmd_if.sink  cmd,
  glpg_pnt_if.source point
);

  localparam int EXT_W = ERR_W - DELTA_W;

  coord_t                    cur_x;
  coord_t                    cur_y;
  coord_t                    end_x;
  coord_t                    end_y;
  logic [DELTA_W-1:0]        delta_x;
  logic signed [DELTA_W-1:0] neg_delta_y;
  logic signed [ERR_W-1:0]   error_term;
  logic                      step_x_neg;
  logic                      step_y_neg;
  floor_t                    line_floor;
  logic                      corners_mode;
  logic                      line_active;
  logic                      y_move_pending;
  logic                      res_valid;
  pnt_t                      result;

  logic                      accept;
  coord_t                    dx_abs;
  coord_t                    dy_abs;
  logic [DELTA_W-1:0]        dx_load;
  logic signed [DELTA_W-1:0] ndy_load;
  logic signed [ERR_W-1:0]   dx_ext;
  logic signed [ERR_W-1:0]   ndy_ext;
  logic signed [ERR_W:0]     e2;
  logic                      do_x;
  logic                      do_y;
  coord_t                    cur_x_next;
  coord_t                    cur_y_next;
  logic signed [ERR_W-1:0]   error_term_next;
  logic                      y_move_pending_next;
  logic                      at_end;

  assign cmd.ready   = !res_valid || point.ready;
  assign accept      = cmd.valid && cmd.ready;
  assign point.valid = res_valid;
  assign point.data  = result;

  always_comb begin
    dx_abs   = (cmd.data.to_x >= cmd.data.from_x) ? cmd.data.to_x - cmd.data.from_x
                                                  : cmd.data.from_x - cmd.data.to_x;
    dy_abs   = (cmd.data.to_y >= cmd.data.from_y) ? cmd.data.to_y - cmd.data.from_y
                                                  : cmd.data.from_y - cmd.data.to_y;
    dx_load  = {1'b0, dx_abs};
    ndy_load = -$signed({1'b0, dy_abs});
  end

  always_comb begin
    dx_ext  = $signed({{EXT_W{1'b0}}, delta_x});
    ndy_ext = $signed({{EXT_W{neg_delta_y[DELTA_W-1]}}, neg_delta_y});
    e2      = $signed({error_term, 1'b0});
    do_x    = e2 >= $signed({ndy_ext[ERR_W-1], ndy_ext});
    do_y    = e2 <= $signed({1'b0, dx_ext});
    cur_x_next          = cur_x;
    cur_y_next          = cur_y;
    error_term_next     = error_term;
    y_move_pending_next = 1'b0;
    if (y_move_pending) begin
      cur_y_next = step_y_neg ? cur_y - 1'b1 : cur_y + 1'b1;
    end else begin
      error_term_next = error_term + (do_x ? ndy_ext : '0) + (do_y ? dx_ext : '0);
      if (do_x) begin
        cur_x_next = step_x_neg ? cur_x - 1'b1 : cur_x + 1'b1;
      end
      if (do_y) begin
        if (corners_mode && do_x) begin
          y_move_pending_next = 1'b1;
        end else begin
          cur_y_next = step_y_neg ? cur_y - 1'b1 : cur_y + 1'b1;
        end
      end
    end
    at_end = (cur_x_next == end_x) && (cur_y_next == end_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active    <= 1'b0;
      y_move_pending <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      if (accept && cmd.data.command == CMD_ADVANCE) begin
        res_valid <= 1'b1;
      end else if (point.ready) begin
        res_valid <= 1'b0;
      end
      if (accept) begin
        if (cmd.data.command == CMD_LOAD) begin
          line_active    <= !((cmd.data.from_x == cmd.data.to_x) &&
                              (cmd.data.from_y == cmd.data.to_y));
          y_move_pending <= 1'b0;
        end else begin
          if (line_active) begin
            y_move_pending <= y_move_pending_next;
            if (at_end) begin
              line_active <= 1'b0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (cmd.data.command == CMD_LOAD) begin
        cur_x        <= cmd.data.from_x;
        cur_y        <= cmd.data.from_y;
        end_x        <= cmd.data.to_x;
        end_y        <= cmd.data.to_y;
        delta_x      <= dx_load;
        neg_delta_y  <= ndy_load;
        error_term   <= $signed({{EXT_W{1'b0}}, dx_load}) +
                        $signed({{EXT_W{ndy_load[DELTA_W-1]}}, ndy_load});
        step_x_neg   <= !(cmd.data.from_x < cmd.data.to_x);
        step_y_neg   <= !(cmd.data.from_y < cmd.data.to_y);
        line_floor   <= cmd.data.floor;
        corners_mode <= cmd.data.with_corners;
      end else if (line_active) begin
        cur_x              <= cur_x_next;
        cur_y              <= cur_y_next;
        error_term         <= error_term_next;
        result.point_x     <= cur_x_next;
        result.point_y     <= cur_y_next;
        result.point_floor <= line_floor;
        result.point_valid <= 1'b1;
        result.last        <= at_end;
      end else begin
        result <= '0;
      end
    end
  end

endmodule

[hw/rtl/glpg_checker.sv]
// Port checker for the grid line point generator, bound to the top level.
// Depends on glpg_pkg for the request codes and widths.
module glpg_checker
  import glpg_pkg::*;
(
  input logic   clk,
  input logic   rst,
  input logic   cmd_valid,
  input logic   cmd_ready,
  input logic   cmd_command,
  input logic   pnt_valid,
  input logic   pnt_ready,
  input coord_t pnt_x,
  input coord_t pnt_y,
  input floor_t pnt_floor,
  input logic   pnt_point_valid,
  input logic   pnt_last
);

  // A stalled point keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    pnt_valid && !pnt_ready |=> pnt_valid && $stable({pnt_x, pnt_y, pnt_floor,
                                                     pnt_point_valid, pnt_last}))
    else $error("stalled point changed");

  // A load request produces no point.
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && cmd_command == CMD_LOAD && (!pnt_valid || pnt_ready)
    |=> !pnt_valid)
    else $error("load request produced a point");

  // An advance request produces a point in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && cmd_command == CMD_ADVANCE |=> pnt_valid)
    else $error("advance request produced no point");

  // An invalid point carries all-zero fields.
  assert property (@(posedge clk) disable iff (rst)
    pnt_valid && !pnt_point_valid |-> pnt_x == '0 && pnt_y == '0 && pnt_floor == '0 && !pnt_last)
    else $error("invalid point has nonzero fields");

  // Only a valid point can end a line.
  assert property (@(posedge clk) disable iff (rst)
    pnt_valid && pnt_last |-> pnt_point_valid)
    else $error("last marker on invalid point");

endmodule

bind grid_line_point_generator glpg_checker u_glpg_checker (
  .clk             (clk),
  .rst             (rst),
  .cmd_valid       (cmd.valid),
  .cmd_ready       (cmd.ready),
  .cmd_command     (cmd.data.command),
  .pnt_valid       (point.valid),
  .pnt_ready       (point.ready),
  .pnt_x           (point.data.point_x),
  .pnt_y           (point.data.point_y),
  .pnt_floor       (point.data.point_floor),
  .pnt_point_valid (point.data.point_valid),
  .pnt_last        (point.data.last)
);
